// ===== rtl/pidw_pkg.sv =====
package pidw_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned NUM_REGS    = 8;
    localparam int unsigned REG_IDX_W   = 3;
    localparam int unsigned NUM_WINDOWS = 128;
    localparam int unsigned PROD_W      = 66;
    localparam int unsigned SAT_W       = 70;
    localparam int unsigned DIV_NUM_W   = 58;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_NUM_W);

    localparam logic [DATA_W-1:0] RATE_NONE = 32'hFFFF_FFFF;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TARGET  = 3'd0,
        REG_SPACING = 3'd1,
        REG_PGAIN   = 3'd2,
        REG_IGAIN   = 3'd3,
        REG_DGAIN   = 3'd4,
        REG_CMIN    = 3'd5,
        REG_CMAX    = 3'd6,
        REG_RATE    = 3'd7
    } t_reg_idx;

    localparam logic [DATA_W-1:0] RST_TARGET  = 32'd0;
    localparam logic [DATA_W-1:0] RST_SPACING = 32'd65536;
    localparam logic [DATA_W-1:0] RST_PGAIN   = 32'd0;
    localparam logic [DATA_W-1:0] RST_IGAIN   = 32'd0;
    localparam logic [DATA_W-1:0] RST_DGAIN   = 32'd0;
    localparam logic [DATA_W-1:0] RST_CMIN    = 32'd0;
    localparam logic [DATA_W-1:0] RST_CMAX    = 32'd65536;
    localparam logic [DATA_W-1:0] RST_RATE    = 32'hFFFF_FFFF;

    typedef enum logic [0:0] {
        OP_UPDATE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    typedef struct packed {
        logic [DATA_W-1:0] target;
        logic [DATA_W-1:0] spacing;
        logic [DATA_W-1:0] pg;
        logic [DATA_W-1:0] ig;
        logic [DATA_W-1:0] dg;
        logic [DATA_W-1:0] cmin;
        logic [DATA_W-1:0] cmax;
        logic [DATA_W-1:0] rate;
    } t_cfg;

    function automatic logic signed [DATA_W-1:0] f_sat(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(64'sd2147483647);
        lo = -SAT_W'(64'sd2147483648);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] f_mulq16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p >>> 16;
        return f_sat(SAT_W'(s));
    endfunction

    function automatic logic signed [DATA_W-1:0] f_clamp(input logic signed [DATA_W-1:0] v,
                                                         input logic signed [DATA_W-1:0] lo,
                                                         input logic signed [DATA_W-1:0] hi);
        if (v < lo) begin
            return lo;
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

endpackage

// ===== rtl/pidw_div.sv =====
module pidw_div
    import pidw_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [DIV_NUM_W-1:0] i_num,
    input  logic        [DATA_W-1:0]    i_den,
    output logic                        o_done,
    output logic signed [DATA_W-1:0]    o_quot
);

    logic                  r_busy;
    logic                  r_done;
    logic                  r_neg;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0]     r_rem;
    logic [DIV_NUM_W-1:0]  r_quo;
    logic [DATA_W:0]       rem_sh;
    logic                  ge;
    logic [DIV_NUM_W-1:0]  num_mag;

    assign num_mag = i_num[DIV_NUM_W-1] ? DIV_NUM_W'(-i_num) : DIV_NUM_W'(i_num);
    assign rem_sh  = {r_rem, r_quo[DIV_NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= num_mag;
            r_neg <= i_num[DIV_NUM_W-1];
        end else if (r_busy) begin
            r_rem <= ge ? DATA_W'(rem_sh - {1'b0, i_den}) : rem_sh[DATA_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], ge};
        end
    end

    always_comb begin
        if (r_neg) begin
            if (r_quo > DIV_NUM_W'(64'd2147483648)) begin
                o_quot = 32'sh8000_0000;
            end else begin
                o_quot = DATA_W'(-r_quo[DATA_W-1:0]);
            end
        end else begin
            if (r_quo > DIV_NUM_W'(64'd2147483647)) begin
                o_quot = 32'sh7FFF_FFFF;
            end else begin
                o_quot = r_quo[DATA_W-1:0];
            end
        end
    end

    assign o_done = r_done;

endmodule

// ===== rtl/pidw_core.sv =====
module pidw_core
    import pidw_pkg::*;
#(
    parameter int unsigned NUM_WIN = NUM_WINDOWS
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_op,
    input  logic        [DATA_W-1:0] i_dt,
    input  logic signed [DATA_W-1:0] i_meas,
    output logic                     o_valid,
    input  logic                     i_out_ready,
    output logic        [DATA_W-1:0] o_value
);

    localparam int unsigned IW = (NUM_WIN > 1) ? $clog2(NUM_WIN) : 1;

    typedef enum logic [17:0] {
        S_IDLE = 18'h00001,
        S_WIN  = 18'h00002,
        S_IDX  = 18'h00004,
        S_DIVW = 18'h00008,
        S_T0   = 18'h00010,
        S_T1   = 18'h00020,
        S_E0   = 18'h00040,
        S_E1   = 18'h00080,
        S_E2   = 18'h00100,
        S_LW   = 18'h00200,
        S_HW   = 18'h00400,
        S_N0   = 18'h00800,
        S_N1   = 18'h01000,
        S_N2   = 18'h02000,
        S_F    = 18'h04000,
        S_B    = 18'h08000,
        S_Z0   = 18'h10000,
        S_OUT  = 18'h20000
    } t_state;

    t_state r_state;

    logic        [DATA_W-1:0] r_dt;
    logic signed [DATA_W-1:0] r_meas;
    logic signed [DATA_W-1:0] r_err;
    logic signed [DATA_W-1:0] r_prev;
    logic signed [DATA_W-1:0] r_deriv;
    logic signed [DATA_W-1:0] r_integ;
    logic signed [DATA_W-1:0] r_acc;
    logic signed [DATA_W-1:0] r_lo;
    logic signed [DATA_W-1:0] r_newv;
    logic signed [DATA_W-1:0] r_drv;
    logic        [DATA_W-1:0] r_out;
    logic                     r_ov;
    logic signed [PROD_W-1:0] r_prod;
    logic        [IW-1:0]     r_widx;
    logic signed [DATA_W-1:0] r_rd;
    logic                     r_rv;
    logic signed [DATA_W-1:0] r_mem [NUM_WIN];
    logic        [NUM_WIN-1:0] r_vld;

    logic signed [DATA_W-1:0] target, pg, ig, dg, cmin, cmax;
    logic signed [DATA_W:0]   mul_a;
    logic signed [DATA_W:0]   mul_b;
    logic signed [DATA_W:0]   diff;
    logic signed [DATA_W:0]   sum_ie;
    logic signed [DATA_W-1:0] sum_sat;
    logic signed [DATA_W-1:0] test;
    logic signed [DATA_W-1:0] edt;
    logic signed [PROD_W-1:0] sh24;
    logic                     div_start;
    logic signed [DIV_NUM_W-1:0] div_num;
    logic        [DATA_W-1:0] div_den;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_q;
    logic                     out_free;
    logic                     accept;
    logic                     smooth;
    logic        [IW-1:0]     widx_calc;

    assign target = i_cfg.target;
    assign pg     = i_cfg.pg;
    assign ig     = i_cfg.ig;
    assign dg     = i_cfg.dg;
    assign cmin   = i_cfg.cmin;
    assign cmax   = i_cfg.cmax;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_ov || i_out_ready;
    assign o_valid  = r_ov;
    assign o_value  = r_out;

    assign diff    = {r_err[DATA_W-1], r_err} - {r_prev[DATA_W-1], r_prev};
    assign sum_ie  = {r_integ[DATA_W-1], r_integ} + {r_err[DATA_W-1], r_err};
    assign sum_sat = f_sat(SAT_W'(sum_ie));
    assign test    = f_mulq16(r_prod);
    assign sh24    = r_prod >>> 24;
    assign edt     = f_sat(SAT_W'(sh24));
    assign smooth  = (i_cfg.rate != RATE_NONE) && (r_prod[PROD_W-1:40] == '0);

    always_comb begin
        if (r_prod[PROD_W-1]) begin
            widx_calc = '0;
        end else if (r_prod[PROD_W-1:32] > (PROD_W-32)'(NUM_WIN - 1)) begin
            widx_calc = IW'(NUM_WIN - 1);
        end else begin
            widx_calc = r_prod[32 +: IW];
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_WIN: begin
                mul_a = {target[DATA_W-1], target};
                mul_b = {1'b0, i_cfg.spacing};
            end
            S_T0, S_N0: begin
                mul_a = {sum_sat[DATA_W-1], sum_sat};
                mul_b = {pg[DATA_W-1], pg};
            end
            S_E0: begin
                mul_a = {r_err[DATA_W-1], r_err};
                mul_b = {1'b0, r_dt};
            end
            S_E1: begin
                mul_a = {edt[DATA_W-1], edt};
                mul_b = {ig[DATA_W-1], ig};
            end
            S_N1: begin
                mul_a = {r_deriv[DATA_W-1], r_deriv};
                mul_b = {dg[DATA_W-1], dg};
            end
            S_N2: begin
                mul_a = {1'b0, r_dt};
                mul_b = {1'b0, i_cfg.rate};
            end
            S_F: begin
                mul_a = {r_newv[DATA_W-1], r_newv} - {r_drv[DATA_W-1], r_drv};
                mul_b = {9'd0, r_prod[39:16]};
            end
            S_IDX: begin
                mul_a = {r_err[DATA_W-1], r_err};
                mul_b = {pg[DATA_W-1], pg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = {diff[DATA_W], diff, 24'd0};
        div_den   = r_dt;
        if (r_state == S_IDX && r_dt != '0) begin
            div_start = 1'b1;
        end else if (r_state == S_E2) begin
            div_start = 1'b1;
            div_num   = {{10{cmin[DATA_W-1]}}, cmin, 16'd0};
            div_den   = pg;
        end else if (r_state == S_LW) begin
            div_start = div_done;
            div_num   = {{10{cmax[DATA_W-1]}}, cmax, 16'd0};
            div_den   = pg;
        end else if (r_state == S_HW) begin
            div_den   = pg;
        end
    end

    pidw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_rd   <= r_mem[r_widx];
        r_rv   <= r_vld[r_widx];
        if (r_state == S_N0) begin
            r_mem[r_widx] <= r_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_vld   <= '0;
            r_prev  <= '0;
            r_drv   <= RST_CMIN;
        end else begin
            if (r_ov && i_out_ready && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_dt   <= i_dt;
                        r_meas <= i_meas;
                        if (i_op == OP_CLEAR) begin
                            r_vld   <= '0;
                            r_prev  <= '0;
                            r_drv   <= cmin;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_WIN;
                        end
                    end
                end
                S_WIN: begin
                    r_err   <= f_sat(SAT_W'(target) - SAT_W'(r_meas));
                    r_state <= S_IDX;
                end
                S_IDX: begin
                    r_widx  <= widx_calc;
                    r_state <= (r_dt == '0) ? S_Z0 : S_DIVW;
                end
                S_Z0: begin
                    r_prev  <= r_err;
                    r_drv   <= f_clamp(test, cmin, cmax);
                    r_state <= S_OUT;
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_deriv <= div_q;
                        r_prev  <= r_err;
                        if (pg > 0) begin
                            r_integ <= r_rv ? r_rd : '0;
                            r_state <= S_T0;
                        end else begin
                            r_integ <= '0;
                            r_state <= S_N0;
                        end
                    end
                end
                S_T0: begin
                    r_state <= S_T1;
                end
                S_T1: begin
                    r_state <= (test > cmin && test < cmax) ? S_E0 : S_N0;
                end
                S_E0: begin
                    r_state <= S_E1;
                end
                S_E1: begin
                    r_state <= S_E2;
                end
                S_E2: begin
                    r_acc   <= f_sat(SAT_W'(r_integ) + SAT_W'(test));
                    r_state <= S_LW;
                end
                S_LW: begin
                    if (div_done) begin
                        r_lo    <= div_q;
                        r_state <= S_HW;
                    end
                end
                S_HW: begin
                    if (div_done) begin
                        r_integ <= f_clamp(r_acc, r_lo, div_q);
                        r_state <= S_N0;
                    end
                end
                S_N0: begin
                    r_vld[r_widx] <= 1'b1;
                    r_state       <= S_N1;
                end
                S_N1: begin
                    r_acc   <= test;
                    r_state <= S_N2;
                end
                S_N2: begin
                    r_newv  <= f_sat(SAT_W'(r_acc) + SAT_W'(test));
                    r_state <= S_F;
                end
                S_F: begin
                    if (smooth) begin
                        r_state <= S_B;
                    end else begin
                        r_drv   <= f_clamp(r_newv, cmin, cmax);
                        r_state <= S_OUT;
                    end
                end
                S_B: begin
                    r_drv   <= f_clamp(f_sat(SAT_W'(r_drv) + SAT_W'(sh24)), cmin, cmax);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_out   <= r_drv;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/pid_controller_windowed_integral_top.sv =====
// PID regulator in signed Q16.16 with one integral slot per setpoint window and
// anti-windup. Each input word is an update (tuser low) or a clear (tuser high);
// each gives exactly one output word. An update with zero delta_time skips the
// bit-serial divider; a normal update waits on it for the derivative, and an
// update that advances the integral waits longer, since the two limit divisions
// run through the same divider. A finished word is held back while the previous
// word still waits in the output register.
// A single 33x33 multiplier is shared by all products. The input is not ready
// while an update or a clear is in progress; a finished word waits in the output register.
// The user must write configuration only while the block is idle; the block itself does not enforce it.
module pid_controller_windowed_integral_top
    import pidw_pkg::*;
#(
    parameter int unsigned NUM_WIN = NUM_WINDOWS
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [63:0]          i_s_axis_tdata,   // delta_time, measured_value
    input  logic                 i_s_axis_tuser,   // op
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [DATA_W-1:0]    o_m_axis_tdata,   // control_value
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_addr,
    input  logic [DATA_W-1:0]    i_cfg_wdata
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target  <= RST_TARGET;
            r_cfg.spacing <= RST_SPACING;
            r_cfg.pg      <= RST_PGAIN;
            r_cfg.ig      <= RST_IGAIN;
            r_cfg.dg      <= RST_DGAIN;
            r_cfg.cmin    <= RST_CMIN;
            r_cfg.cmax    <= RST_CMAX;
            r_cfg.rate    <= RST_RATE;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_TARGET:  r_cfg.target  <= i_cfg_wdata;
                REG_SPACING: r_cfg.spacing <= i_cfg_wdata;
                REG_PGAIN:   r_cfg.pg      <= i_cfg_wdata;
                REG_IGAIN:   r_cfg.ig      <= i_cfg_wdata;
                REG_DGAIN:   r_cfg.dg      <= i_cfg_wdata;
                REG_CMIN:    r_cfg.cmin    <= i_cfg_wdata;
                REG_CMAX:    r_cfg.cmax    <= i_cfg_wdata;
                REG_RATE:    r_cfg.rate    <= i_cfg_wdata;
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    pidw_core #(
        .NUM_WIN (NUM_WIN)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_dt        (i_s_axis_tdata[31:0]),
        .i_meas      (i_s_axis_tdata[63:32]),
        .o_valid     (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_value     (o_m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after accept");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result without work");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("not empty after reset");
`endif

endmodule
